### design/stp_pkg.sv
// Shared constants, prompt codes and result type for the serial time entry parser.
package stp_pkg;

    localparam logic [7:0] START_CHAR   = 8'h74;
    localparam logic [7:0] CR_CHAR      = 8'h0D;
    localparam logic [7:0] DIGIT_LO     = 8'h30;
    localparam logic [7:0] DIGIT_HI     = 8'h39;
    localparam int         RADIX        = 10;
    localparam int         HOUR_LIMIT   = 24;
    localparam int         MINSEC_LIMIT = 60;
    localparam logic [7:0] ACC_MAX      = 8'hFF;

    typedef enum logic [2:0] {
        PROMPT_NONE   = 3'd0,
        PROMPT_HOUR   = 3'd1,
        PROMPT_MINUTE = 3'd2,
        PROMPT_SECOND = 3'd3,
        PROMPT_ENDED  = 3'd4
    } t_prompt;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        t_prompt    prompt_code;
        logic       time_valid;
        logic [4:0] new_hour;
        logic [5:0] new_minute;
        logic [5:0] new_second;
    } t_result;

endpackage

### design/stp_parse.sv
// Entry state machine: holds the entry mode, digit accumulator and accepted fields.
module stp_parse
    import stp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HOUR   = 2'd1,
        MODE_MINUTE = 2'd2,
        MODE_SECOND = 2'd3
    } t_mode;

    t_mode       r_mode;
    t_mode       n_mode;
    logic [7:0]  r_acc;
    logic [7:0]  n_acc;
    logic [4:0]  r_hour;
    logic [4:0]  n_hour;
    logic [5:0]  r_minute;
    logic [5:0]  n_minute;
    logic [11:0] w_acc_sum;
    logic        w_is_digit;
    logic        w_hour_ok;
    logic        w_minsec_ok;

    // The low nibble of an ASCII digit is its value.
    assign w_acc_sum   = 12'({4'b0, r_acc}) * 12'(RADIX) + {8'b0, i_byte[3:0]};
    assign w_is_digit  = (i_byte >= DIGIT_LO) && (i_byte <= DIGIT_HI);
    assign w_hour_ok   = r_acc < 8'(HOUR_LIMIT);
    assign w_minsec_ok = r_acc < 8'(MINSEC_LIMIT);

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_hour   = r_hour;
        n_minute = r_minute;
        o_result = '0;
        if (r_mode == MODE_IDLE) begin
            if (i_byte == START_CHAR) begin
                n_mode               = MODE_HOUR;
                n_acc                = '0;
                o_result.prompt_code = PROMPT_HOUR;
            end
        end else begin
            o_result.echo_valid = 1'b1;
            o_result.echo_byte  = i_byte;
            if (i_byte == CR_CHAR) begin
                // Every path through a carriage return clears the accumulator.
                n_acc = '0;
                case (r_mode)
                    MODE_HOUR: begin
                        if (w_hour_ok) begin
                            n_hour               = r_acc[4:0];
                            n_mode               = MODE_MINUTE;
                            o_result.prompt_code = PROMPT_MINUTE;
                        end else begin
                            n_mode               = MODE_IDLE;
                            o_result.prompt_code = PROMPT_ENDED;
                        end
                    end
                    MODE_MINUTE: begin
                        if (w_minsec_ok) begin
                            n_minute             = r_acc[5:0];
                            n_mode               = MODE_SECOND;
                            o_result.prompt_code = PROMPT_SECOND;
                        end else begin
                            n_mode               = MODE_IDLE;
                            o_result.prompt_code = PROMPT_ENDED;
                        end
                    end
                    default: begin
                        if (w_minsec_ok) begin
                            o_result.time_valid = 1'b1;
                            o_result.new_hour   = r_hour;
                            o_result.new_minute = r_minute;
                            o_result.new_second = r_acc[5:0];
                        end
                        n_mode               = MODE_IDLE;
                        o_result.prompt_code = PROMPT_ENDED;
                    end
                endcase
            end else if (w_is_digit) begin
                n_acc = (w_acc_sum > {4'b0, ACC_MAX}) ? ACC_MAX : w_acc_sum[7:0];
            end else begin
                n_mode               = MODE_IDLE;
                n_acc                = '0;
                o_result.prompt_code = PROMPT_ENDED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_acc    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_hour   <= n_hour;
            r_minute <= n_minute;
        end
    end

endmodule

### design/serial_time_entry_parser_core.sv
// Top level of the serial time entry parser: input register, parser and result register.
//
// Usage: received bytes enter on the rx channel (i_rx_valid, o_rx_ready, i_rx_byte),
// one word per byte. Each byte yields exactly one result word on the output
// channel (o_valid, i_ready), carrying the echo, the prompt code and, when an
// entry completes, the new hour, minute and second.
// A 't' while idle starts an entry; hours, minutes and seconds follow, each
// as decimal digits ended by a carriage return.
// Path: a byte is held in the input register until the parser takes it, and
// its result is then stored in the result register, which drives o_valid
// and the result fields.
// Throughput is one byte per cycle while the receiver takes each result; the
// next parser state and the result are formed combinationally between the two registers.
// When the receiver stalls, the result register holds and the input
// register takes one more byte; after that o_rx_ready drops until the
// result is taken.
// Reset empties both registers and returns the parser to idle with a zero
// accumulator and zero held fields.
module serial_time_entry_parser_core
    import stp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_byte,
    output logic [2:0] o_prompt_code,
    output logic       o_time_valid,
    output logic [4:0] o_new_hour,
    output logic [5:0] o_new_minute,
    output logic [5:0] o_new_second
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_out_free;
    logic       w_advance;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_rx_ready = !r_in_valid || w_advance;

    stp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_byte   (r_in_byte),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_echo_valid  = r_out.echo_valid;
    assign o_echo_byte   = r_out.echo_byte;
    assign o_prompt_code = r_out.prompt_code;
    assign o_time_valid  = r_out.time_valid;
    assign o_new_hour    = r_out.new_hour;
    assign o_new_minute  = r_out.new_minute;
    assign o_new_second  = r_out.new_second;

    // A completed entry always closes with the entry-ended prompt.
    a_time_ends_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_time_valid) |-> (o_prompt_code == PROMPT_ENDED))
        else $error("time reported without entry-ended prompt");

    // Reported time fields are always in range.
    a_time_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_time_valid) |->
        (o_new_hour < 5'(HOUR_LIMIT)) && (o_new_minute < 6'(MINSEC_LIMIT))
        && (o_new_second < 6'(MINSEC_LIMIT)))
        else $error("reported time out of range");

    // Bytes are only echoed during an entry, so an idle result echoes nothing.
    a_no_echo_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_echo_valid) |-> (o_echo_byte == 8'h00))
        else $error("echo byte set without echo");

    // A stalled result is held while another byte waits in the input register.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |=> (r_in_valid && r_out_valid))
        else $error("word lost under backpressure");

endmodule

### tb/tb_serial_time_entry_parser_core.sv
// Testbench for the serial time entry parser: directed script plus random entries, self-checked.
`timescale 1ns / 1ps

module tb_serial_time_entry_parser_core
    import stp_pkg::*;
();

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HOUR   = 2'd1,
        MODE_MINUTE = 2'd2,
        MODE_SECOND = 2'd3
    } t_entry_mode;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        t_result    want;
    } t_script_row;

    localparam int      ACTIVE_TARGET = 1900;
    localparam t_result QUIET_RESULT  = '0;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_rx_valid;
    logic       o_rx_ready;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_ready;
    logic       o_echo_valid;
    logic [7:0] o_echo_byte;
    logic [2:0] o_prompt_code;
    logic       o_time_valid;
    logic [4:0] o_new_hour;
    logic [5:0] o_new_minute;
    logic [5:0] o_new_second;

    // Model state of the parser.
    t_entry_mode pr_mode;
    logic [7:0]  pr_acc;
    logic [4:0]  pr_hour;
    logic [5:0]  pr_minute;

    t_result     pending_results[$];
    t_script_row script[$];
    t_result     got_word;
    t_result     want_word;
    int          fails;
    int          active_words;
    int          send_burst;
    int          recv_burst;
    int          stall_left;

    serial_time_entry_parser_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_echo_valid (o_echo_valid),
        .o_echo_byte  (o_echo_byte),
        .o_prompt_code(o_prompt_code),
        .o_time_valid (o_time_valid),
        .o_new_hour   (o_new_hour),
        .o_new_minute (o_new_minute),
        .o_new_second (o_new_second)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result result_of(input logic ev, input logic [7:0] eb,
                                          input t_prompt pc, input logic tv,
                                          input logic [4:0] h, input logic [5:0] m,
                                          input logic [5:0] s);
        t_result r;
        r.echo_valid  = ev;
        r.echo_byte   = eb;
        r.prompt_code = pc;
        r.time_valid  = tv;
        r.new_hour    = h;
        r.new_minute  = m;
        r.new_second  = s;
        return r;
    endfunction

    function automatic void end_entry(ref t_result r);
        pr_mode       = MODE_IDLE;
        pr_acc        = '0;
        r.prompt_code = PROMPT_ENDED;
    endfunction

    // Advances the model state by one received byte and returns the word it yields.
    function automatic t_result next_result(input logic [7:0] b);
        t_result r;
        int      sum;
        r = QUIET_RESULT;
        if (pr_mode == MODE_IDLE) begin
            if (b == START_CHAR) begin
                pr_mode       = MODE_HOUR;
                pr_acc        = '0;
                r.prompt_code = PROMPT_HOUR;
            end
            return r;
        end
        r.echo_valid = 1'b1;
        r.echo_byte  = b;
        if (b == CR_CHAR) begin
            case (pr_mode)
                MODE_HOUR: begin
                    if (pr_acc < HOUR_LIMIT) begin
                        pr_hour       = pr_acc[4:0];
                        pr_acc        = '0;
                        pr_mode       = MODE_MINUTE;
                        r.prompt_code = PROMPT_MINUTE;
                    end else begin
                        end_entry(r);
                    end
                end
                MODE_MINUTE: begin
                    if (pr_acc < MINSEC_LIMIT) begin
                        pr_minute     = pr_acc[5:0];
                        pr_acc        = '0;
                        pr_mode       = MODE_SECOND;
                        r.prompt_code = PROMPT_SECOND;
                    end else begin
                        end_entry(r);
                    end
                end
                default: begin
                    if (pr_acc < MINSEC_LIMIT) begin
                        r.time_valid = 1'b1;
                        r.new_hour   = pr_hour;
                        r.new_minute = pr_minute;
                        r.new_second = pr_acc[5:0];
                    end
                    end_entry(r);
                end
            endcase
        end else if (b >= DIGIT_LO && b <= DIGIT_HI) begin
            sum = int'(pr_acc) * RADIX + int'(b - DIGIT_LO);
            pr_acc = (sum > int'(ACC_MAX)) ? ACC_MAX : sum[7:0];
        end else begin
            end_entry(r);
        end
        return r;
    endfunction

    function automatic int draw_wait(ref int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(20, 80);
        end
        return $urandom_range(0, 14);
    endfunction

    // Offers one byte, waits for it to be taken, then files the word it must produce.
    task automatic send_word(input logic [7:0] b, input bit typed, input t_result want);
        int      gap;
        t_result r;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        r = next_result(b);
        if (r.echo_valid || r.prompt_code != PROMPT_NONE) begin
            active_words++;
        end
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed, input t_result want);
        t_script_row row;
        row.rx    = b;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endtask

    task automatic send_decimal(input int v);
        if (v >= 100) send_word(DIGIT_LO + 8'(v / 100), 1'b0, QUIET_RESULT);
        if (v >= 10) send_word(DIGIT_LO + 8'((v / 10) % 10), 1'b0, QUIET_RESULT);
        send_word(DIGIT_LO + 8'(v % 10), 1'b0, QUIET_RESULT);
    endtask

    // One field of an entry: mostly in range, sometimes too large or broken off.
    task automatic send_field(input int lim);
        int         kind;
        int         v;
        int         n;
        logic [7:0] junk;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            v = $urandom_range(0, lim - 1);
            if (!(v == 0 && $urandom_range(0, 1) == 1)) begin
                if ($urandom_range(0, 4) == 0) send_word(DIGIT_LO, 1'b0, QUIET_RESULT);
                send_decimal(v);
            end
            send_word(CR_CHAR, 1'b0, QUIET_RESULT);
        end else if (kind < 82) begin
            n = $urandom_range(1, 4);
            repeat (n) send_word(DIGIT_LO + 8'($urandom_range(0, 9)), 1'b0, QUIET_RESULT);
            send_word(CR_CHAR, 1'b0, QUIET_RESULT);
        end else if (kind < 90) begin
            v = ($urandom_range(0, 1) == 0) ? lim : $urandom_range(lim, 255);
            send_decimal(v);
            send_word(CR_CHAR, 1'b0, QUIET_RESULT);
        end else begin
            n = $urandom_range(0, 2);
            repeat (n) send_word(DIGIT_LO + 8'($urandom_range(0, 9)), 1'b0, QUIET_RESULT);
            if ($urandom_range(0, 3) == 0) begin
                junk = START_CHAR;
            end else begin
                do junk = 8'($urandom_range(0, 255));
                while ((junk >= DIGIT_LO && junk <= DIGIT_HI) || junk == CR_CHAR);
            end
            send_word(junk, 1'b0, QUIET_RESULT);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // Receiver: random stall after each taken word, and the result check.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_word = result_of(o_echo_valid, o_echo_byte, t_prompt'(o_prompt_code),
                                 o_time_valid, o_new_hour, o_new_minute, o_new_second);
            if (pending_results.size() == 0) begin
                $error("result word with no expected word waiting");
                fails++;
            end else begin
                want_word = pending_results.pop_front();
                check_field("echo_valid", want_word.echo_valid, got_word.echo_valid);
                check_field("echo_byte", want_word.echo_byte, got_word.echo_byte);
                check_field("prompt_code", want_word.prompt_code, got_word.prompt_code);
                check_field("time_valid", want_word.time_valid, got_word.time_valid);
                check_field("new_hour", want_word.new_hour, got_word.new_hour);
                check_field("new_minute", want_word.new_minute, got_word.new_minute);
                check_field("new_second", want_word.new_second, got_word.new_second);
            end
            stall_left = draw_wait(recv_burst);
            if (stall_left > 0) i_ready <= 1'b0;
        end else if (!i_ready) begin
            if (stall_left <= 1) i_ready <= 1'b1;
            stall_left = stall_left - 1;
        end
    end

    initial begin
        #2_000_000;
        $display("** serial_time_entry_parser_core: FAILED **");
        $finish;
    end

    initial begin
        int         f;
        logic [7:0] noise;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_rx_valid   = 1'b0;
        i_rx_byte    = '0;
        i_ready      = 1'b1;
        fails        = 0;
        active_words = 0;
        send_burst   = 0;
        recv_burst   = 0;
        stall_left   = 0;
        pr_mode      = MODE_IDLE;
        pr_acc       = '0;
        pr_hour      = '0;
        pr_minute    = '0;

        // Idle bytes at both extremes, then the largest valid time.
        add_row(8'h00, 1'b1, QUIET_RESULT);
        add_row(8'hFF, 1'b1, QUIET_RESULT);
        add_row(START_CHAR, 1'b1,
                result_of(1'b0, 8'h00, PROMPT_HOUR, 1'b0, 5'd0, 6'd0, 6'd0));
        add_row(DIGIT_LO + 8'd2, 1'b0, QUIET_RESULT);
        add_row(DIGIT_LO + 8'd3, 1'b0, QUIET_RESULT);
        add_row(CR_CHAR, 1'b0, QUIET_RESULT);
        add_row(DIGIT_LO + 8'd5, 1'b0, QUIET_RESULT);
        add_row(DIGIT_HI, 1'b0, QUIET_RESULT);
        add_row(CR_CHAR, 1'b0, QUIET_RESULT);
        add_row(DIGIT_LO + 8'd5, 1'b0, QUIET_RESULT);
        add_row(DIGIT_HI, 1'b0, QUIET_RESULT);
        add_row(CR_CHAR, 1'b1,
                result_of(1'b1, CR_CHAR, PROMPT_ENDED, 1'b1, 5'd23, 6'd59, 6'd59));
        // Three empty fields give midnight.
        add_row(START_CHAR, 1'b0, QUIET_RESULT);
        add_row(CR_CHAR, 1'b1,
                result_of(1'b1, CR_CHAR, PROMPT_MINUTE, 1'b0, 5'd0, 6'd0, 6'd0));
        add_row(CR_CHAR, 1'b1,
                result_of(1'b1, CR_CHAR, PROMPT_SECOND, 1'b0, 5'd0, 6'd0, 6'd0));
        add_row(CR_CHAR, 1'b1,
                result_of(1'b1, CR_CHAR, PROMPT_ENDED, 1'b1, 5'd0, 6'd0, 6'd0));
        // The accumulator saturates, then the hour is out of range.
        add_row(START_CHAR, 1'b0, QUIET_RESULT);
        add_row(DIGIT_HI, 1'b0, QUIET_RESULT);
        add_row(DIGIT_HI, 1'b0, QUIET_RESULT);
        add_row(DIGIT_HI, 1'b0, QUIET_RESULT);
        add_row(CR_CHAR, 1'b1,
                result_of(1'b1, CR_CHAR, PROMPT_ENDED, 1'b0, 5'd0, 6'd0, 6'd0));
        // Hour of exactly the limit.
        add_row(START_CHAR, 1'b0, QUIET_RESULT);
        add_row(DIGIT_LO + 8'd2, 1'b0, QUIET_RESULT);
        add_row(DIGIT_LO + 8'd4, 1'b0, QUIET_RESULT);
        add_row(CR_CHAR, 1'b1,
                result_of(1'b1, CR_CHAR, PROMPT_ENDED, 1'b0, 5'd0, 6'd0, 6'd0));
        // A non-digit just below the digit range aborts.
        add_row(START_CHAR, 1'b0, QUIET_RESULT);
        add_row(DIGIT_LO - 8'd1, 1'b1,
                result_of(1'b1, DIGIT_LO - 8'd1, PROMPT_ENDED, 1'b0, 5'd0, 6'd0, 6'd0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) send_word(script[i].rx, script[i].typed, script[i].want);

        while (active_words < ACTIVE_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                noise = 8'($urandom_range(0, 255));
                send_word(noise, 1'b0, QUIET_RESULT);
            end else begin
                send_word(START_CHAR, 1'b0, QUIET_RESULT);
                f = 0;
                while (f < 3 && pr_mode != MODE_IDLE) begin
                    send_field(f == 0 ? HOUR_LIMIT : MINSEC_LIMIT);
                    f++;
                end
            end
        end
        i_rx_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fails == 0) begin
            $display("** serial_time_entry_parser_core: PASSED **");
        end else begin
            $display("** serial_time_entry_parser_core: FAILED **");
        end
        $finish;
    end

endmodule
